@@ rtl/epm_pkg.sv @@
// ----------------------------------------------------------------------------
// Equal-power pan mix: shared package
// Widths, fixed-point constants, divider tables and the lane control struct.
// ----------------------------------------------------------------------------
package epm_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int ACC_W       = 32;
	localparam int SUM_W       = ACC_W + 1;
	localparam int PAN_W       = 16;
	localparam int VOL_W       = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int STEP_W      = 17;
	localparam int GAIN_W      = 27;
	localparam int MUL_W       = 32;

	// stream payload widths, padded to whole bytes
	localparam int IN_DATA_W   = ((2 * SAMPLE_BITS + 2 * ACC_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((2 * ACC_W + 7) / 8) * 8;

	// mix datapath: signed sample times zero-extended gain
	localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
	localparam int RND_W       = PROD_W - SAMPLE_BITS;
	localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (SAMPLE_BITS - 1);

	// Q1.30 constants
	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
	localparam logic [30:0] SQRT2_Q30   = 31'd1518500250;

	// Horner terms of the sine series, with floor(2^32 / k) for each divisor
	localparam int TERMS      = 5;
	localparam int TERM_IDX_W = $clog2(TERMS);
	localparam logic [6:0]  DIV_K   [TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [29:0] RECIP_K [TERMS] = '{
		30'd39045157, 30'd59652323, 30'd102261126, 30'd214748364, 30'd715827882
	};

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [PAN_W-1:0] PAN_RESET = '0;
	localparam logic [VOL_W-1:0] VOL_RESET = 16'd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAN    = 2'd0,
		REG_VOL    = 2'd1,
		REG_BYPASS = 2'd2,
		REG_SUPP   = 2'd3
	} cfg_reg_t;

	// pipeline and sequencer control from the top level to each lane
	typedef struct packed {
		logic start;
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} epm_ctl_t;

endpackage

@@ rtl/epm_gain.sv @@
// ----------------------------------------------------------------------------
// Equal-power pan mix: gain sequencer
// Works out one channel gain in Q3.24 from the angle step count and volume,
// through one shared registered multiplier, a step per cycle.
// ----------------------------------------------------------------------------
module epm_gain import epm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [STEP_W-1:0] steps,
	input  logic [VOL_W-1:0]  volume,
	output logic              busy,
	output logic [GAIN_W-1:0] gain
);

	typedef enum logic [10:0] {
		G_IDLE  = 11'b000_0000_0001,
		G_ANG   = 11'b000_0000_0010,
		G_SQR   = 11'b000_0000_0100,
		G_X2    = 11'b000_0000_1000,
		G_TERM  = 11'b000_0001_0000,
		G_RECIP = 11'b000_0010_0000,
		G_CORR  = 11'b000_0100_0000,
		G_SIN   = 11'b000_1000_0000,
		G_CLAMP = 11'b001_0000_0000,
		G_VOL   = 11'b010_0000_0000,
		G_ROUND = 11'b100_0000_0000
	} gstate_t;

	gstate_t                 state_q;
	logic [TERM_IDX_W-1:0]   idx_q;
	logic [2*MUL_W-1:0]      prod_q;
	logic [30:0]             x_q;
	logic [31:0]             x2_q;
	logic [31:0]             y_q;
	logic [30:0]             t_q;
	logic [GAIN_W-1:0]       gain_q;

	logic [MUL_W-1:0]        mul_a;
	logic [MUL_W-1:0]        mul_b;
	logic [31:0]             sin_raw;
	logic [30:0]             sin_c;
	logic [31:0]             q0;
	logic [38:0]             qk;
	logic [38:0]             rem;
	logic [31:0]             q;
	logic [47:0]             vol_rnd;

	assign sin_raw = prod_q[61:30];
	assign sin_c   = (sin_raw > 32'(Q30_ONE)) ? Q30_ONE : sin_raw[30:0];

	// reciprocal estimate is low by at most one: fix with one compare
	assign q0  = prod_q[63:32];
	assign qk  = 39'(q0) * 39'(DIV_K[idx_q]);
	assign rem = 39'(y_q) - qk;
	assign q   = (rem >= 39'(DIV_K[idx_q])) ? q0 + 32'd1 : q0;

	assign vol_rnd = 48'(prod_q[46:0]) + 48'h8_0000;

	always_comb begin
		unique case (state_q)
			G_ANG: begin
				mul_a = MUL_W'(steps);
				mul_b = MUL_W'(PI_HALF_Q30);
			end
			G_SQR: begin
				mul_a = MUL_W'(prod_q[46:16]);
				mul_b = MUL_W'(prod_q[46:16]);
			end
			G_TERM: begin
				mul_a = x2_q;
				mul_b = MUL_W'(t_q);
			end
			G_RECIP: begin
				mul_a = prod_q[61:30];
				mul_b = MUL_W'(RECIP_K[idx_q]);
			end
			G_SIN: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(t_q);
			end
			G_CLAMP: begin
				mul_a = MUL_W'(sin_c);
				mul_b = MUL_W'(SQRT2_Q30);
			end
			G_VOL: begin
				mul_a = prod_q[61:30];
				mul_b = MUL_W'(volume);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				G_IDLE: begin
					if (start) begin
						state_q <= G_ANG;
					end
					idx_q <= '0;
				end
				G_ANG:   state_q <= G_SQR;
				G_SQR:   state_q <= G_X2;
				G_X2:    state_q <= G_TERM;
				G_TERM:  state_q <= G_RECIP;
				G_RECIP: state_q <= G_CORR;
				G_CORR: begin
					if (idx_q == TERM_IDX_W'(TERMS - 1)) begin
						state_q <= G_SIN;
					end else begin
						state_q <= G_TERM;
						idx_q   <= idx_q + 1'b1;
					end
				end
				G_SIN:   state_q <= G_CLAMP;
				G_CLAMP: state_q <= G_VOL;
				G_VOL:   state_q <= G_ROUND;
				G_ROUND: state_q <= G_IDLE;
				default: state_q <= G_IDLE;
			endcase
		end
	end

	// datapath registers: capture each intermediate as its product lands
	always_ff @(posedge clk) begin
		if (state_q == G_ANG) begin
			t_q <= Q30_ONE;
		end
		if (state_q == G_SQR) begin
			x_q <= prod_q[46:16];
		end
		if (state_q == G_X2) begin
			x2_q <= prod_q[61:30];
		end
		if (state_q == G_RECIP) begin
			y_q <= prod_q[61:30];
		end
		if (state_q == G_CORR) begin
			t_q <= Q30_ONE - q[30:0];
		end
		if (state_q == G_ROUND) begin
			gain_q <= vol_rnd[20 +: GAIN_W];
		end
	end

	assign busy = (state_q != G_IDLE);
	assign gain = gain_q;

endmodule

@@ rtl/epm_lane.sv @@
// ----------------------------------------------------------------------------
// Equal-power pan mix: channel lane
// One channel: its gain sequencer, then scale, round half away from zero,
// accumulate and saturate over three pipeline stages.
// ----------------------------------------------------------------------------
module epm_lane import epm_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  epm_ctl_t                      ctl,
	input  logic [STEP_W-1:0]             steps,
	input  logic [VOL_W-1:0]              volume,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [ACC_W-1:0]       accum,
	output logic                          busy,
	output logic signed [ACC_W-1:0]       acc_s3,
	output logic signed [ACC_W-1:0]       sum_s3
);

	logic [GAIN_W-1:0]          gain;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0]    acc_s1;
	logic signed [RND_W-1:0]    rnd_s2;
	logic signed [ACC_W-1:0]    acc_s2;
	logic signed [PROD_W-1:0]   rnd;
	logic signed [SUM_W-1:0]    sum;
	logic signed [ACC_W-1:0]    sat;

	epm_gain u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.start),
		.steps  (steps),
		.volume (volume),
		.busy   (busy),
		.gain   (gain)
	);

	// bias by half, less one when negative, then an arithmetic shift
	assign rnd = prod_s1 + $signed(ROUND_BIAS)
	             - $signed({{(PROD_W-1){1'b0}}, prod_s1[PROD_W-1]});

	assign sum = SUM_W'(acc_s2) + SUM_W'(rnd_s2);

	always_comb begin
		if (sum[SUM_W-1] != sum[SUM_W-2]) begin
			sat = sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
		end else begin
			sat = sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			prod_s1 <= PROD_W'(sample) * $signed({1'b0, gain});
			acc_s1  <= accum;
		end
		if (ctl.en_s2) begin
			rnd_s2 <= rnd[PROD_W-1:SAMPLE_BITS];
			acc_s2 <= acc_s1;
		end
		if (ctl.en_s3) begin
			sum_s3 <= sat;
			acc_s3 <= acc_s2;
		end
	end

endmodule

@@ rtl/equal_power_pan_mix_core.sv @@
// ----------------------------------------------------------------------------
// Equal-power pan mix core
// Adds a pan-scaled stereo frame onto the master-bus accumulator pair.
// ----------------------------------------------------------------------------
// One stereo frame is accepted per clock while the gains are ready and
// no stall holds the pipeline; its mixed accumulator pair passes stages one,
// two and three into the output register; left and right run in two lanes
// side by side and merge into that register, and bubbles in the pipeline
// let new words in while a result waits. The channel gains hang on the
// register values only: after reset and after every register write, each
// lane's gain sequencer works them out through its one multiplier, and
// s_axis_tready stays low until both are done.
module equal_power_pan_mix_core import epm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	// input frames
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// sample_left, sample_right, accum_left, accum_right (lowest bit up)
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tlast,
	// mixed results
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// mix_left, mix_right (lowest bit up)
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast
);

	logic [PAN_W-1:0]        pan_q;
	logic [VOL_W-1:0]        vol_q;
	logic                    bypass_q;
	logic                    supp_q;
	logic                    stale_q;

	logic                    v_s1, v_s2, v_s3;
	logic                    last_s1, last_s2, last_s3;
	logic                    rdy_s1, rdy_s2, rdy_s3;
	logic                    en_out;
	logic                    gain_busy;
	logic                    gain_ok;
	logic                    busy_l, busy_r;
	epm_ctl_t                ctl;

	logic [PAN_W-1:0]        pan_u;
	logic [STEP_W-1:0]       steps_l, steps_r;
	logic signed [ACC_W-1:0] acc_l_s3, acc_r_s3, sum_l_s3, sum_r_s3;
	logic signed [ACC_W-1:0] mix_l, mix_r;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_q    <= PAN_RESET;
			vol_q    <= VOL_RESET;
			bypass_q <= 1'b0;
			supp_q   <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PAN:    pan_q    <= cfg_wdata[PAN_W-1:0];
				REG_VOL:    vol_q    <= cfg_wdata[VOL_W-1:0];
				REG_BYPASS: bypass_q <= cfg_wdata[0];
				REG_SUPP:   supp_q   <= cfg_wdata[0];
				default:    ;
			endcase
		end
	end

	// gains go stale on any write; a write during a run forces a rerun
	assign gain_busy = busy_l | busy_r;
	assign gain_ok   = !stale_q && !gain_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q <= 1'b1;
		end else if (cfg_wen) begin
			stale_q <= 1'b1;
		end else if (ctl.start) begin
			stale_q <= 1'b0;
		end
	end

	// pan offset to [0, 65535]: right steps u, left steps 65536 - u
	assign pan_u   = {~pan_q[PAN_W-1], pan_q[PAN_W-2:0]};
	assign steps_r = {1'b0, pan_u};
	assign steps_l = STEP_W'(1 << PAN_W) - {1'b0, pan_u};

	// stage handshake: a stage takes a word when empty or when passing one on
	assign en_out = v_s3 && (!m_axis_tvalid || m_axis_tready);
	assign rdy_s3 = !v_s3 || !m_axis_tvalid || m_axis_tready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign s_axis_tready = gain_ok && rdy_s1;

	assign ctl.start = stale_q && !gain_busy;
	assign ctl.en_s1 = s_axis_tvalid && s_axis_tready;
	assign ctl.en_s2 = v_s1 && rdy_s2;
	assign ctl.en_s3 = v_s2 && rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			v_s1          <= ctl.en_s1 || (v_s1 && !ctl.en_s2);
			v_s2          <= ctl.en_s2 || (v_s2 && !ctl.en_s3);
			v_s3          <= ctl.en_s3 || (v_s3 && !en_out);
			m_axis_tvalid <= en_out || (m_axis_tvalid && !m_axis_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			last_s1 <= s_axis_tlast;
		end
		if (ctl.en_s2) begin
			last_s2 <= last_s1;
		end
		if (ctl.en_s3) begin
			last_s3 <= last_s2;
		end
	end

	epm_lane u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.steps  (steps_l),
		.volume (vol_q),
		.sample (s_axis_tdata[SAMPLE_BITS-1:0]),
		.accum  (s_axis_tdata[2*SAMPLE_BITS +: ACC_W]),
		.busy   (busy_l),
		.acc_s3 (acc_l_s3),
		.sum_s3 (sum_l_s3)
	);

	epm_lane u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.steps  (steps_r),
		.volume (vol_q),
		.sample (s_axis_tdata[SAMPLE_BITS +: SAMPLE_BITS]),
		.accum  (s_axis_tdata[2*SAMPLE_BITS+ACC_W +: ACC_W]),
		.busy   (busy_r),
		.acc_s3 (acc_r_s3),
		.sum_s3 (sum_r_s3)
	);

	// merge: pass the accumulators through untouched when routed off
	assign mix_l = (bypass_q || supp_q) ? acc_l_s3 : sum_l_s3;
	assign mix_r = (bypass_q || supp_q) ? acc_r_s3 : sum_r_s3;

	always_ff @(posedge clk) begin
		if (en_out) begin
			m_axis_tdata <= OUT_DATA_W'({mix_r, mix_l});
			m_axis_tlast <= last_s3;
		end
	end

`ifndef SYNTH
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> v_s1)
		else $error("accepted word did not reach stage one");

	a_write_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |=> !s_axis_tready)
		else $error("input taken before gains were recomputed");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		gain_busy |-> !s_axis_tready)
		else $error("input taken while gain sequencer runs");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en_out) |=> (v_s3 && $stable(sum_l_s3) && $stable(sum_r_s3)))
		else $error("stalled stage three word changed");
`endif

endmodule
